FILE: rtl/config_text_tokenizer_top_defines.svh
// assertion macros shared by the tokenizer rtl
`ifndef CONFIG_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define CONFIG_TEXT_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ctt_pkg.sv
// types, constants and helpers for the config text tokenizer
package ctt_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LINE_W      = 24;
    localparam int COL_W       = 16;
    localparam int SLOTS       = 3;

    typedef logic [OFFSET_BITS-1:0] offs_t;
    typedef logic [LINE_W-1:0]      line_t;
    typedef logic [COL_W-1:0]       col_t;

    typedef enum logic [3:0] {
        KIND_END        = 4'd0,
        KIND_UNEXPECTED = 4'd1,
        KIND_IDENT      = 4'd2,
        KIND_NUMBER     = 4'd3,
        KIND_STRING     = 4'd4,
        KIND_LCURLY     = 4'd5,
        KIND_RCURLY     = 4'd6,
        KIND_EQUAL      = 4'd7,
        KIND_COMMA      = 4'd8
    } kind_t;

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_IDENT   = 6'b000010,
        MODE_NUMBER  = 6'b000100,
        MODE_STRING  = 6'b001000,
        MODE_COMMENT = 6'b010000,
        MODE_ENDED   = 6'b100000
    } mode_t;

    // packed so that kind sits in the low bits
    typedef struct packed {
        logic [15:0] column;
        logic [23:0] line;
        logic [31:0] length;
        logic [31:0] offset;
        kind_t       kind;
    } token_t;

    typedef struct packed {
        logic [SLOTS-1:0]   valid;
        token_t [SLOTS-1:0] tok;
    } cand_t;

    localparam int TOKEN_W = $bits(token_t);
    localparam int TDATA_W = ((TOKEN_W + 7) / 8) * 8;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function automatic token_t make_tok(input kind_t k, input offs_t off, input offs_t len,
                                        input line_t ln, input col_t cl);
        token_t t;
        t.kind   = k;
        t.offset = 32'(off);
        t.length = 32'(len);
        t.line   = ln;
        t.column = cl;
        return t;
    endfunction

    function automatic logic flush_valid(input mode_t m);
        return m == MODE_IDENT || m == MODE_NUMBER || m == MODE_STRING;
    endfunction

    // token closed by end of text or by a byte that cannot extend it
    function automatic token_t flush_tok(input mode_t m, input offs_t ts, input offs_t pos,
                                         input line_t ln, input col_t cl);
        token_t t;
        if (m == MODE_STRING) begin
            t = make_tok(KIND_UNEXPECTED, offs_t'(ts + 1'b1), offs_t'(pos - ts - 1'b1),
                         ln, cl);
        end else begin
            t = make_tok((m == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER, ts,
                         offs_t'(pos - ts), ln, cl);
        end
        return t;
    endfunction

endpackage

FILE: rtl/ctt_scan.sv
// scanner state and per-beat token decode
`include "config_text_tokenizer_top_defines.svh"

module ctt_scan (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic [7:0]     text_byte,
    input  logic           final_byte,
    output ctt_pkg::cand_t cand
);

    ctt_pkg::mode_t mode_reg, mode_next;
    ctt_pkg::offs_t pos_reg, pos_next;
    ctt_pkg::offs_t ts_reg, ts_next;
    ctt_pkg::line_t line_reg, line_next;
    ctt_pkg::col_t  col_reg, col_next;
    ctt_pkg::line_t sline_reg, sline_next;
    ctt_pkg::col_t  scol_reg, scol_next;

    always_comb begin
        ctt_pkg::mode_t m;
        ctt_pkg::offs_t pos;
        ctt_pkg::offs_t ts;
        ctt_pkg::line_t ln;
        ctt_pkg::line_t sl;
        ctt_pkg::col_t  cl;
        ctt_pkg::col_t  sc;
        logic           go;

        mode_next  = mode_reg;
        pos_next   = pos_reg;
        ts_next    = ts_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        cand       = '0;

        m  = mode_reg;
        ts = ts_reg;
        sl = sline_reg;
        sc = scol_reg;
        go = 1'b0;

        pos = ctt_pkg::offs_t'(pos_reg + 1'b1);
        ln  = line_reg;
        cl  = col_reg;
        if (text_byte == ctt_pkg::CH_LF) begin
            if (line_reg != '1) ln = ctt_pkg::line_t'(line_reg + 1'b1);
            cl = '0;
        end else if (col_reg != '1) begin
            cl = ctt_pkg::col_t'(col_reg + 1'b1);
        end

        if (accept) begin
            if (mode_reg == ctt_pkg::MODE_ENDED) begin
                if (final_byte) begin
                    mode_next  = ctt_pkg::MODE_IDLE;
                    pos_next   = '0;
                    ts_next    = '0;
                    line_next  = '0;
                    col_next   = '0;
                    sline_next = '0;
                    scol_next  = '0;
                end
            end else if (text_byte == ctt_pkg::CH_NUL) begin
                cand.valid[0] = ctt_pkg::flush_valid(mode_reg);
                cand.tok[0]   = ctt_pkg::flush_tok(mode_reg, ts_reg, pos_reg,
                                                   sline_reg, scol_reg);
                cand.valid[2] = 1'b1;
                cand.tok[2]   = ctt_pkg::make_tok(ctt_pkg::KIND_END, pos_reg, '0,
                                                  line_reg, col_reg);
                mode_next = ctt_pkg::MODE_ENDED;
                if (final_byte) begin
                    mode_next  = ctt_pkg::MODE_IDLE;
                    pos_next   = '0;
                    ts_next    = '0;
                    line_next  = '0;
                    col_next   = '0;
                    sline_next = '0;
                    scol_next  = '0;
                end
            end else begin
                unique case (mode_reg)
                    ctt_pkg::MODE_IDENT: begin
                        if (!(ctt_pkg::is_letter(text_byte) || ctt_pkg::is_digit(text_byte)
                              || text_byte == ctt_pkg::CH_UNDER)) begin
                            cand.valid[0] = 1'b1;
                            cand.tok[0]   = ctt_pkg::flush_tok(mode_reg, ts_reg, pos_reg,
                                                               sline_reg, scol_reg);
                            m  = ctt_pkg::MODE_IDLE;
                            go = 1'b1;
                        end
                    end
                    ctt_pkg::MODE_NUMBER: begin
                        if (!ctt_pkg::is_digit(text_byte)) begin
                            cand.valid[0] = 1'b1;
                            cand.tok[0]   = ctt_pkg::flush_tok(mode_reg, ts_reg, pos_reg,
                                                               sline_reg, scol_reg);
                            m  = ctt_pkg::MODE_IDLE;
                            go = 1'b1;
                        end
                    end
                    ctt_pkg::MODE_STRING: begin
                        if (text_byte == ctt_pkg::CH_QUOTE) begin
                            cand.valid[1] = 1'b1;
                            cand.tok[1]   = ctt_pkg::make_tok(ctt_pkg::KIND_STRING,
                                                ctt_pkg::offs_t'(ts_reg + 1'b1),
                                                ctt_pkg::offs_t'(pos_reg - ts_reg - 1'b1),
                                                sline_reg, scol_reg);
                            m = ctt_pkg::MODE_IDLE;
                        end
                    end
                    ctt_pkg::MODE_COMMENT: begin
                        if (text_byte == ctt_pkg::CH_LF) m = ctt_pkg::MODE_IDLE;
                    end
                    ctt_pkg::MODE_IDLE: begin
                        go = 1'b1;
                    end
                    ctt_pkg::MODE_ENDED: begin
                        go = 1'b0;
                    end
                endcase

                if (go) begin
                    priority if (ctt_pkg::is_blank(text_byte)) begin
                        m = ctt_pkg::MODE_IDLE;
                    end else if (text_byte == ctt_pkg::CH_HASH) begin
                        m = ctt_pkg::MODE_COMMENT;
                    end else if (ctt_pkg::is_letter(text_byte) || ctt_pkg::is_digit(text_byte)
                                 || text_byte == ctt_pkg::CH_QUOTE) begin
                        m  = ctt_pkg::is_letter(text_byte) ? ctt_pkg::MODE_IDENT :
                             ctt_pkg::is_digit(text_byte)  ? ctt_pkg::MODE_NUMBER :
                                                             ctt_pkg::MODE_STRING;
                        ts = pos_reg;
                        sl = line_reg;
                        sc = col_reg;
                    end else begin
                        cand.valid[1] = 1'b1;
                        unique case (text_byte)
                            ctt_pkg::CH_LCURLY: cand.tok[1].kind = ctt_pkg::KIND_LCURLY;
                            ctt_pkg::CH_RCURLY: cand.tok[1].kind = ctt_pkg::KIND_RCURLY;
                            ctt_pkg::CH_EQUAL:  cand.tok[1].kind = ctt_pkg::KIND_EQUAL;
                            ctt_pkg::CH_COMMA:  cand.tok[1].kind = ctt_pkg::KIND_COMMA;
                            default:            cand.tok[1].kind = ctt_pkg::KIND_UNEXPECTED;
                        endcase
                        cand.tok[1].offset = 32'(pos_reg);
                        cand.tok[1].length = 32'd1;
                        cand.tok[1].line   = line_reg;
                        cand.tok[1].column = col_reg;
                        m = ctt_pkg::MODE_IDLE;
                    end
                end

                if (final_byte) begin
                    if (ctt_pkg::flush_valid(m)) begin
                        cand.valid[1] = 1'b1;
                        cand.tok[1]   = ctt_pkg::flush_tok(m, ts, pos, sl, sc);
                    end
                    cand.valid[2] = 1'b1;
                    cand.tok[2]   = ctt_pkg::make_tok(ctt_pkg::KIND_END, pos, '0, ln, cl);
                    mode_next  = ctt_pkg::MODE_IDLE;
                    pos_next   = '0;
                    ts_next    = '0;
                    line_next  = '0;
                    col_next   = '0;
                    sline_next = '0;
                    scol_next  = '0;
                end else begin
                    mode_next  = m;
                    pos_next   = pos;
                    ts_next    = ts;
                    line_next  = ln;
                    col_next   = cl;
                    sline_next = sl;
                    scol_next  = sc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= ctt_pkg::MODE_IDLE;
            pos_reg   <= '0;
            ts_reg    <= '0;
            line_reg  <= '0;
            col_reg   <= '0;
            sline_reg <= '0;
            scol_reg  <= '0;
        end else begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            ts_reg    <= ts_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
        end
    end

    `CTT_ASSERT_NOW(a_ended_silent, accept && mode_reg == ctt_pkg::MODE_ENDED,
        cand.valid == '0, "byte after end of text produced a token")
    `CTT_ASSERT_NEXT(a_final_resets, accept && final_byte,
        pos_reg == '0 && mode_reg == ctt_pkg::MODE_IDLE, "final byte did not restart scan")
    `CTT_ASSERT_NEXT(a_nul_ends,
        accept && text_byte == ctt_pkg::CH_NUL && !final_byte
            && mode_reg != ctt_pkg::MODE_ENDED,
        mode_reg == ctt_pkg::MODE_ENDED, "zero byte did not end the text")

endmodule

FILE: rtl/ctt_out_buf.sv
// three-slot token buffer, drains one beat per out_ready cycle
`include "config_text_tokenizer_top_defines.svh"

module ctt_out_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  ctt_pkg::cand_t  cand,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output ctt_pkg::token_t out_tok,
    output logic            out_last
);

    logic [ctt_pkg::SLOTS-1:0] valid_reg, valid_next;
    ctt_pkg::token_t [ctt_pkg::SLOTS-1:0] tok_reg;
    logic [ctt_pkg::SLOTS-1:0] head;
    logic pop;

    assign head      = valid_reg & (~valid_reg + 1'b1);
    assign out_valid = |valid_reg;
    assign out_last  = $onehot(valid_reg);
    assign pop       = out_valid && out_ready;
    assign in_ready  = (valid_reg == '0) || (out_last && out_ready);

    always_comb begin
        out_tok = tok_reg[2];
        priority if (valid_reg[0]) begin
            out_tok = tok_reg[0];
        end else if (valid_reg[1]) begin
            out_tok = tok_reg[1];
        end else begin
            out_tok = tok_reg[2];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (pop) valid_next = valid_reg & ~head;
        if (load) valid_next = cand.valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) tok_reg <= cand.tok;
    end

    `CTT_ASSERT_NOW(a_no_overwrite, load,
        (valid_reg & ~(pop ? head : '0)) == '0, "new byte overwrote a pending token")
    `CTT_ASSERT_NEXT(a_pop_count, pop && !load,
        $countones(valid_reg) == $countones($past(valid_reg)) - 1, "pop lost or kept a slot")
    `CTT_ASSERT_NEXT(a_load_shows, load && cand.valid != '0,
        out_valid, "loaded tokens not presented")

endmodule

FILE: rtl/config_text_tokenizer_top.sv
// config text tokenizer: a byte's first token beat is shown in the cycle after its acceptance
// accepts one byte per cycle while each byte yields at most one token and m_tready is high
// a multi-token byte holds s_tready low till its last beat goes (one slot per m_tready cycle)
// aresetn low clears scan state, line, column and offset and drops pending tokens
module config_text_tokenizer_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // text_byte
    input  logic                        s_tlast,  // final_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ctt_pkg::TDATA_W-1:0] m_tdata,  // token_kind, text_offset, text_length,
                                                  // line_index, column_index, zero pad
    output logic                        m_tlast   // run_last
);

    logic            accept;
    ctt_pkg::cand_t  cand;
    ctt_pkg::token_t out_tok;

    assign accept = s_tvalid && s_tready;

    ctt_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .text_byte  (s_tdata),
        .final_byte (s_tlast),
        .cand       (cand)
    );

    ctt_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .cand      (cand),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok),
        .out_last  (m_tlast)
    );

    assign m_tdata = ctt_pkg::TDATA_W'(out_tok);

endmodule
